[design/scl_pkg.sv]
`default_nettype none

package scl_pkg;

   // Field widths of one result beat
   localparam int CODE_W  = 3;
   localparam int VALUE_W = 64;
   localparam int COUNT_W = 5;
   localparam int BYTE_W  = 8;
   localparam int NIBBLES = VALUE_W / 4;

   // Command codes
   localparam logic [CODE_W-1:0] CODE_NAME    = 3'd0;
   localparam logic [CODE_W-1:0] CODE_REBOOT  = 3'd1;
   localparam logic [CODE_W-1:0] CODE_READ    = 3'd2;
   localparam logic [CODE_W-1:0] CODE_ERASE   = 3'd3;
   localparam logic [CODE_W-1:0] CODE_WRITE   = 3'd4;
   localparam logic [CODE_W-1:0] CODE_UNKNOWN = 3'd5;

   // Special characters
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_0     = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_9     = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_A     = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_F     = 8'h46;
   localparam logic [3:0]        NIBBLE_TEN = 4'd10;

   // Keyword table: byte 0 of each word in bits 7:0, unused bytes zero
   localparam int KW_COUNT = 5;
   localparam int KW_MAX   = 6;
   localparam int KW_LEN_W = 3;

   localparam logic [KW_MAX*BYTE_W-1:0] KW_TEXT [KW_COUNT] = '{
      48'h0000_656D_616E,   // name
      48'h746F_6F62_6572,   // reboot
      48'h0000_6461_6572,   // read
      48'h0065_7361_7265,   // erase
      48'h0065_7469_7277    // write
   };
   localparam logic [KW_LEN_W-1:0] KW_LEN [KW_COUNT] = '{
      3'd4, 3'd6, 3'd4, 3'd5, 3'd5
   };
   localparam logic [CODE_W-1:0] KW_CODE [KW_COUNT] = '{
      CODE_NAME, CODE_REBOOT, CODE_READ, CODE_ERASE, CODE_WRITE
   };

   typedef struct packed {
      logic [CODE_W-1:0]  code;
      logic [VALUE_W-1:0] value;
      logic [COUNT_W-1:0] count;
   } scl_result_type;

endpackage

`default_nettype wire

[design/scl_line.sv]
`default_nettype none

module scl_line
   import scl_pkg::*;
#(
   parameter int WORD_CAPACITY = 30,
   parameter int DIGIT_LIMIT   = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [BYTE_W-1:0] rx_byte,
   output logic                   result_valid,
   output scl_result_type         result
);

   localparam int LEN_W = $clog2(WORD_CAPACITY);
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(WORD_CAPACITY - 1);

   logic [LEN_W-1:0]   word_length_ff, word_length_in;
   logic               in_argument_ff, in_argument_in;
   logic [VALUE_W-1:0] argument_bits_ff, argument_bits_in;
   logic [COUNT_W-1:0] argument_digits_ff, argument_digits_in;
   logic [KW_COUNT-1:0] match_ff, match_in;

   logic              is_end;
   logic              is_space;
   logic              is_digit;
   logic              is_hex_letter;
   logic [3:0]        nibble;
   logic [BYTE_W-1:0] kw_char [KW_COUNT];
   logic [CODE_W-1:0] code;

   // Classify the byte
   always_comb begin
      is_end        = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
      is_space      = (rx_byte == CHAR_SPACE);
      is_digit      = (rx_byte >= CHAR_0) && (rx_byte <= CHAR_9);
      is_hex_letter = (rx_byte >= CHAR_A) && (rx_byte <= CHAR_F);
      if (is_digit) begin
         nibble = 4'(rx_byte - CHAR_0);
      end else begin
         nibble = 4'(rx_byte - CHAR_A) + NIBBLE_TEN;
      end
   end

   // Pick the keyword byte at the current word position
   always_comb begin
      for (int k = 0; k < KW_COUNT; k++) begin
         kw_char[k] = '0;
         for (int j = 0; j < KW_MAX; j++) begin
            if (word_length_ff == LEN_W'(j)) begin
               kw_char[k] = KW_TEXT[k][j*BYTE_W +: BYTE_W];
            end
         end
      end
   end

   // Resolve the command at line end: a keyword matches only at full length
   always_comb begin
      code = CODE_UNKNOWN;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (match_ff[k] && (word_length_ff == LEN_W'(KW_LEN[k]))) begin
            code = KW_CODE[k];
         end
      end
   end

   assign result_valid  = is_end && (word_length_ff != '0);
   assign result.code  = code;
   assign result.value = argument_bits_ff;
   assign result.count = argument_digits_ff;

   // Next line state
   always_comb begin
      word_length_in     = word_length_ff;
      in_argument_in     = in_argument_ff;
      argument_bits_in   = argument_bits_ff;
      argument_digits_in = argument_digits_ff;
      match_in           = match_ff;
      priority if (is_end) begin
         word_length_in     = '0;
         in_argument_in     = 1'b0;
         argument_bits_in   = '0;
         argument_digits_in = '0;
         match_in           = '1;
      end else if (is_space) begin
         in_argument_in = 1'b1;
      end else if (!in_argument_ff) begin
         // store a word byte unless the word is full
         if (word_length_ff < LEN_LIMIT) begin
            word_length_in = word_length_ff + LEN_W'(1);
            for (int k = 0; k < KW_COUNT; k++) begin
               if ((word_length_ff >= LEN_W'(KW_LEN[k])) || (rx_byte != kw_char[k])) begin
                  match_in[k] = 1'b0;
               end
            end
         end
      end else if (is_digit || is_hex_letter) begin
         // pack the nibble, first digit on top
         if (argument_digits_ff < COUNT_W'(DIGIT_LIMIT)) begin
            argument_digits_in = argument_digits_ff + COUNT_W'(1);
            for (int i = 0; i < NIBBLES; i++) begin
               if (argument_digits_ff == COUNT_W'(i)) begin
                  argument_bits_in[VALUE_W-4-4*i +: 4] = nibble;
               end
            end
         end
      end
   end

   // Advance the line state on each processed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         word_length_ff     <= '0;
         in_argument_ff     <= 1'b0;
         argument_bits_ff   <= '0;
         argument_digits_ff <= '0;
         match_ff           <= '1;
      end else if (step) begin
         word_length_ff     <= word_length_in;
         in_argument_ff     <= in_argument_in;
         argument_bits_ff   <= argument_bits_in;
         argument_digits_ff <= argument_digits_in;
         match_ff           <= match_in;
      end
   end

endmodule

`default_nettype wire

[design/serial_command_line_parser.sv]
// Serial command line parser. Each req beat carries one received byte. Bytes
// before the first space build the command word (up to WORD_CAPACITY-1 bytes,
// the rest dropped); after it, uppercase hex digits 0-9/A-F are packed first
// digit on top into a 64-bit argument, up to DIGIT_LIMIT digits, and all other
// bytes are ignored. CR or LF ends the line: a non-empty word gives one rsp
// beat with the command code (0 name, 1 reboot, 2 read, 3 erase, 4 write,
// 5 unknown), the argument and the digit count, and the line state clears.
// One byte is taken per clock cycle while the rsp side does not stall; a byte
// is held in an input register and its result is then loaded into the rsp
// register. The rate is set by the line state registers, updated once per byte.
`default_nettype none

module serial_command_line_parser
   import scl_pkg::*;
#(
   parameter int WORD_CAPACITY = 30,
   parameter int DIGIT_LIMIT   = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata    // [2:0] command_code, [66:3] key_value,
                                         // [71:67] digit_count
);

   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              rsp_valid_ff;
   scl_result_type    rsp_data_ff;

   logic           out_free;
   logic           advance;
   logic           result_valid;
   scl_result_type result;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || advance;

   // Hold the incoming beat
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   scl_line #(
      .WORD_CAPACITY (WORD_CAPACITY),
      .DIGIT_LIMIT   (DIGIT_LIMIT)
   ) u_line (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .rx_byte      (in_byte_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   // Load or drain the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= advance && result_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result_valid) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.count, rsp_data_ff.value, rsp_data_ff.code};

endmodule

`default_nettype wire

[test/tb_serial_command_line_parser.sv]
`timescale 1ns / 100ps

module tb_serial_command_line_parser;
   import scl_pkg::*;

   localparam int WORD_KEEP   = 29;   // bytes of the command word that are kept
   localparam int DIGIT_LIMIT = 16;

   typedef struct {
      logic [CODE_W-1:0]  code;
      logic [VALUE_W-1:0] value;
      logic [COUNT_W-1:0] count;
   } command_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;     // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;          // [2:0] command_code, [66:3] key_value,
                                    // [71:67] digit_count

   // Line state of the predictor
   logic [7:0]         word_buf [WORD_KEEP];
   int                 word_len = 0;
   bit                 arg_mode = 1'b0;
   logic [VALUE_W-1:0] arg_value = '0;
   int                 arg_digits = 0;

   command_beat_type expected_commands [$];
   int  mismatches = 0;
   int  bytes_sent = 0;
   int  lines_sent = 0;
   int  commands_checked = 0;
   bit  idle_enable = 1'b1;
   int  stall_left = 0;

   string kw_names [5] = '{"name", "reboot", "read", "erase", "write"};
   logic [CODE_W-1:0] kw_codes [5] = '{CODE_NAME, CODE_REBOOT, CODE_READ, CODE_ERASE,
                                       CODE_WRITE};

   serial_command_line_parser uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 40) $display("mismatch at %0t ns: %s", $time, msg);
   endtask

   // Match the stored word against the keyword table
   function automatic logic [CODE_W-1:0] classify_word();
      bit same;
      for (int i = 0; i < 5; i++) begin
         same = (word_len == kw_names[i].len());
         for (int j = 0; same && j < kw_names[i].len(); j++)
            if (word_buf[j] != kw_names[i][j]) same = 1'b0;
         if (same) return kw_codes[i];
      end
      return CODE_UNKNOWN;
   endfunction

   function automatic void clear_line();
      word_len   = 0;
      arg_mode   = 1'b0;
      arg_value  = '0;
      arg_digits = 0;
   endfunction

   // Advance the line state by one accepted byte and queue any command it ends
   function automatic void absorb_byte(input logic [7:0] b);
      command_beat_type cmd;
      logic [3:0]       nib;
      if (b == CHAR_CR || b == CHAR_LF) begin
         if (word_len > 0) begin
            cmd.code  = classify_word();
            cmd.value = arg_value;
            cmd.count = COUNT_W'(arg_digits);
            expected_commands.push_back(cmd);
         end
         clear_line();
      end else if (b == CHAR_SPACE) begin
         arg_mode = 1'b1;
      end else if (!arg_mode) begin
         if (word_len < WORD_KEEP) begin
            word_buf[word_len] = b;
            word_len++;
         end
      end else if ((b >= CHAR_0 && b <= CHAR_9) || (b >= CHAR_A && b <= CHAR_F)) begin
         nib = (b <= CHAR_9) ? 4'(b - CHAR_0) : 4'(b - CHAR_A) + NIBBLE_TEN;
         if (arg_digits < DIGIT_LIMIT) begin
            arg_value[(15 - arg_digits) * 4 +: 4] = nib;
            arg_digits++;
         end
      end
   endfunction

   // Drive one byte, with an optional idle burst ahead of it
   task automatic send_byte(input logic [7:0] b);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      absorb_byte(b);
      bytes_sent++;
      if (b == CHAR_CR || b == CHAR_LF) lines_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic send_line(input string s, input bit use_cr);
      send_text(s);
      send_byte(use_cr ? CHAR_CR : CHAR_LF);
   endtask

   // Hold off the sender until every queued command has come back
   task automatic wait_for_drain();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (expected_commands.size() > 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
   endtask

   // Check each result beat and pick the next stall on the rsp side
   always @(posedge clock) begin
      command_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         commands_checked++;
         if (expected_commands.size() == 0) begin
            report_mismatch($sformatf("unexpected result beat %h", rsp_tdata));
         end else begin
            want = expected_commands.pop_front();
            if (rsp_tdata[2:0] !== want.code)
               report_mismatch($sformatf("command_code %0d, want %0d",
                                         rsp_tdata[2:0], want.code));
            if (rsp_tdata[66:3] !== want.value)
               report_mismatch($sformatf("key_value %h, want %h",
                                         rsp_tdata[66:3], want.value));
            if (rsp_tdata[71:67] !== want.count)
               report_mismatch($sformatf("digit_count %0d, want %0d",
                                         rsp_tdata[71:67], want.count));
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 18) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [7:0] hex_char(input int d);
      return (d < 10) ? 8'(CHAR_0 + d) : 8'(CHAR_A + d - 10);
   endfunction

   // Any byte other than space, CR and LF
   function automatic logic [7:0] word_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == CHAR_SPACE || b == CHAR_CR || b == CHAR_LF);
      return b;
   endfunction

   task automatic test_keywords();
      send_line("name", 1'b1);
      send_line("reboot 1", 1'b0);
      send_line("read 00FF", 1'b1);
      send_line("erase", 1'b0);
      send_line("write 0123456789ABCDEF", 1'b1);
      send_line("Name 9", 1'b0);
      send_line("reads", 1'b1);
   endtask

   task automatic test_overflow();
      // word longer than what is kept, then an argument cut to the digit limit
      send_line("abcdefghijklmnopqrstuvwxyz0123456789", 1'b0);
      send_line("erase FEDCBA9876543210FFFF", 1'b1);
   endtask

   task automatic test_ignored_bytes();
      send_text("read  12 ab-G");
      send_byte(8'hC0);
      send_text("3  4");
      send_byte(8'h7F);
      send_byte(CHAR_LF);
      // zero, high and top bytes inside the word
      send_byte(8'h00);
      send_byte(8'h80);
      send_byte(8'hFF);
      send_byte(CHAR_LF);
   endtask

   task automatic test_empty_lines();
      send_byte(CHAR_LF);
      send_byte(CHAR_CR);
      send_line(" 1A", 1'b1);
      send_line("   ", 1'b0);
   endtask

   // One command line, mostly well formed, sometimes broken
   task automatic random_line();
      int    kind;
      int    n;
      string kw;
      kind = $urandom_range(0, 11);
      if (kind <= 5) begin
         send_text(kw_names[$urandom_range(0, 4)]);
      end else if (kind == 6) begin
         // near miss: keyword with one byte changed or a byte added
         kw = kw_names[$urandom_range(0, 4)];
         if ($urandom_range(0, 1)) kw[$urandom_range(0, kw.len() - 1)] = "x";
         else kw = {kw, "s"};
         send_text(kw);
      end else if (kind <= 8) begin
         repeat ($urandom_range(1, 12)) send_byte(word_byte());
      end else if (kind == 9) begin
         repeat ($urandom_range(25, 40)) send_byte(word_byte());
      end
      if ($urandom_range(0, 3) != 0) begin
         send_byte(CHAR_SPACE);
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 22) : $urandom_range(0, 16);
         repeat (n) begin
            if ($urandom_range(0, 7) == 0) send_byte(word_byte());
            else if ($urandom_range(0, 15) == 0) send_byte(CHAR_SPACE);
            else send_byte(hex_char($urandom_range(0, 15)));
         end
      end
      // raw noise, line ends included
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      send_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
   endtask

   task automatic test_random_lines();
      while (bytes_sent < 600) random_line();
      wait_for_drain();
      while (bytes_sent < 1000) random_line();
   endtask

   task automatic test_streaming();
      wait_for_drain();
      idle_enable = 1'b0;
      while (bytes_sent < 1180) random_line();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_keywords();
      test_overflow();
      test_ignored_bytes();
      test_empty_lines();
      test_random_lines();
      test_streaming();
      wait_for_drain();
      if (expected_commands.size() > 0)
         report_mismatch($sformatf("%0d results never arrived", expected_commands.size()));
      $display("sent %0d bytes in %0d lines, checked %0d command results",
               bytes_sent, lines_sent, commands_checked);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Abort a hung run
   initial begin
      #5000000;
      $display("FAIL");
      $finish;
   end

endmodule

[sim.f]
design/scl_pkg.sv
design/scl_line.sv
design/serial_command_line_parser.sv
test/tb_serial_command_line_parser.sv
